// ===== rtl/core/tftc_pkg.sv =====
// ----------------------------------------------------------------------------
// tftc_pkg
// Types, codes and sizes shared by the TFTP flash transfer control block.
// ----------------------------------------------------------------------------
package tftc_pkg;

   localparam int BLOCK_BYTES  = 512;
   localparam int FUNC_W       = 16;
   localparam int BLOCK_W      = 16;
   localparam int PAY_W        = 10;
   localparam int ADDR_W       = 25;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = ADDR_W;
   // full byte address of a block before it is cut to the flash width
   localparam int FULL_W       = BLOCK_W + $clog2(BLOCK_BYTES);
   localparam int CMP_W        = (FULL_W > ADDR_W) ? FULL_W : ADDR_W;

   localparam logic [FUNC_W-1:0] OP_RRQ  = 16'd1;
   localparam logic [FUNC_W-1:0] OP_WRQ  = 16'd2;
   localparam logic [FUNC_W-1:0] OP_DATA = 16'd3;
   localparam logic [FUNC_W-1:0] OP_ACK  = 16'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLASH_END     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPLOAD_ENABLE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERIFY_ONLY   = 8'd2;

   localparam logic [ADDR_W-1:0] FLASH_END_RESET = 25'd131071;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_ACK   = 3'd1,
      KIND_DATA  = 3'd2,
      KIND_ERROR = 3'd3,
      KIND_FINAL = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      LOADER_KEEP    = 2'd0,
      LOADER_STOP    = 2'd1,
      LOADER_RESTART = 2'd2,
      LOADER_START   = 2'd3
   } loader_type;

   typedef enum logic [2:0] {
      CLS_RRQ,
      CLS_WRQ,
      CLS_DATA,
      CLS_ACK,
      CLS_ERR
   } cls_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [BLOCK_W-1:0] block_number;
      logic [PAY_W-1:0]   payload_length;
   } req_type;

   typedef struct packed {
      kind_type           reply_kind;
      logic [BLOCK_W-1:0] reply_block;
      logic [ADDR_W-1:0]  flash_address;
      logic               write_enable;
      logic [PAY_W-1:0]   pad_start;
      logic               last_block;
      loader_type         loader_command;
      logic               retry_fetch;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] flash_end;
      logic              upload_enable;
      logic              verify_only;
   } cfg_type;

   // classified packet handed from the front to the back
   typedef struct packed {
      cls_type            cls;
      logic [BLOCK_W-1:0] block_number;
      logic [PAY_W-1:0]   pad_start;
      logic               short_block;
   } cmd_type;

endpackage

// ===== rtl/core/tftp_flash_transfer_control.sv =====
// ----------------------------------------------------------------------------
// tftp_flash_transfer_control
// Reply sequencer for a TFTP flash bootloader: one decision per packet header.
// ----------------------------------------------------------------------------
// A header waits in the command queue, is decided, and its result is held in the result queue.
// Throughput: one header per cycle while neither queue is full, set by the decision stage.
// Each side has a two-entry queue, so either side may stall alone.
// Synchronous reset clears the queues and transfer state and loads register
// defaults; no clearing pass is needed.
module tftp_flash_transfer_control
   import tftc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;
   logic    cmd_push;
   cmd_type cmd_in;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd_out;

   assign req_full = cmd_full;

   tftc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tftc_front u_front (
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (cmd_full),
      .cfg        (cfg),
      .cmd_push   (cmd_push),
      .cmd        (cmd_in)
   );

   tftc_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_out)
   );

   tftc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/tftc_csr.sv =====
// ----------------------------------------------------------------------------
// tftc_csr
// Configuration registers, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module tftc_csr
   import tftc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_end     <= FLASH_END_RESET;
         cfg_ff.upload_enable <= 1'b1;
         cfg_ff.verify_only   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FLASH_END:     cfg_ff.flash_end     <= csr_data;
            CSR_UPLOAD_ENABLE: cfg_ff.upload_enable <= csr_data[0];
            CSR_VERIFY_ONLY:   cfg_ff.verify_only   <= csr_data[0];
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/core/tftc_front.sv =====
// ----------------------------------------------------------------------------
// tftc_front
// Decodes the opcode of each packet header and saturates its payload length.
// ----------------------------------------------------------------------------
module tftc_front
   import tftc_pkg::*;
(
   input  logic    req_push,
   input  req_type req_data,
   input  logic    queue_full,
   input  cfg_type cfg,
   output logic    cmd_push,
   output cmd_type cmd
);

   logic over_block;

   assign cmd_push   = req_push && !queue_full;
   assign over_block = 32'(req_data.payload_length) > 32'(BLOCK_BYTES);

   always_comb begin
      cmd.block_number = req_data.block_number;
      cmd.pad_start    = over_block ? PAY_W'(BLOCK_BYTES) : req_data.payload_length;
      cmd.short_block  = 32'(cmd.pad_start) < 32'(BLOCK_BYTES);
      unique case (req_data.func)
         OP_RRQ:  cmd.cls = cfg.upload_enable ? CLS_RRQ : CLS_ERR;
         OP_ACK:  cmd.cls = cfg.upload_enable ? CLS_ACK : CLS_ERR;
         OP_WRQ:  cmd.cls = CLS_WRQ;
         OP_DATA: cmd.cls = CLS_DATA;
         default: cmd.cls = CLS_ERR;
      endcase
   end

endmodule

// ===== rtl/core/tftc_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tftc_cmd_queue
// Two-entry queue of classified packets between front and back.
// ----------------------------------------------------------------------------
module tftc_cmd_queue
   import tftc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/tftc_back.sv =====
// ----------------------------------------------------------------------------
// tftc_back
// Transfer state and reply decision, with a two-entry result queue.
// ----------------------------------------------------------------------------
module tftc_back
   import tftc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic               upload_mode_ff, upload_mode_in;
   logic [BLOCK_W-1:0] blocks_done_ff, blocks_done_in;
   logic               finished_ff, finished_in;

   rsp_type    res_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   rsp_type            res;
   logic               in_window;
   logic               same_block;
   logic               send;
   logic               err;
   logic [BLOCK_W-1:0] blk_prev;
   logic [FULL_W-1:0]  data_base;
   logic [FULL_W-1:0]  send_base;
   logic               past_end;

   assign cmd_pop   = !cmd_empty && (count_ff != 2'd2);
   assign rsp_empty = count_ff == 2'd0;
   assign rsp_data  = res_ff[rd_ptr_ff];

   always_comb begin
      in_window  = (cmd.block_number >= blocks_done_ff) &&
                   ({1'b0, cmd.block_number} <= ({1'b0, blocks_done_ff} + 17'd1));
      same_block = cmd.block_number == blocks_done_ff;
      blk_prev   = cmd.block_number - BLOCK_W'(1);
      data_base  = FULL_W'(blk_prev) * FULL_W'(BLOCK_BYTES);
      // a read request restarts at block zero, an ack sends the block after it
      send_base  = (cmd.cls == CLS_RRQ) ? '0 : FULL_W'(cmd.block_number) * FULL_W'(BLOCK_BYTES);
      past_end   = CMP_W'(send_base) > CMP_W'(cfg.flash_end);
   end

   always_comb begin
      res            = '0;
      res.reply_kind = KIND_NONE;
      res.loader_command = LOADER_KEEP;
      upload_mode_in = upload_mode_ff;
      blocks_done_in = blocks_done_ff;
      finished_in    = finished_ff;
      send           = 1'b0;
      err            = 1'b0;

      unique case (cmd.cls)
         CLS_RRQ: begin
            upload_mode_in     = 1'b1;
            blocks_done_in     = '0;
            finished_in        = 1'b0;
            res.loader_command = LOADER_STOP;
            send               = 1'b1;
         end
         CLS_ACK: begin
            if (!upload_mode_ff || !in_window) begin
               err = 1'b1;
            end else begin
               blocks_done_in = cmd.block_number;
               send           = 1'b1;
            end
         end
         CLS_WRQ: begin
            upload_mode_in = 1'b0;
            blocks_done_in = '0;
            finished_in    = 1'b0;
            res.reply_kind = KIND_ACK;
         end
         CLS_DATA: begin
            res.loader_command = LOADER_STOP;
            if (upload_mode_ff || !in_window) begin
               err = 1'b1;
            end else if (same_block) begin
               // duplicate: acknowledge again, leave state alone
               res.reply_kind  = KIND_ACK;
               res.reply_block = cmd.block_number;
            end else begin
               res.flash_address = ADDR_W'(data_base);
               res.write_enable  = !cfg.verify_only;
               res.pad_start     = cmd.pad_start;
               if (cmd.short_block) begin
                  finished_in        = 1'b1;
                  res.last_block     = 1'b1;
                  res.loader_command = LOADER_START;
               end
               blocks_done_in  = cmd.block_number;
               res.reply_kind  = KIND_ACK;
               res.reply_block = cmd.block_number;
            end
         end
         default: begin
            err = 1'b1;
         end
      endcase

      if (send) begin
         if (finished_in) begin
            res.loader_command = LOADER_RESTART;
            res.reply_kind     = KIND_NONE;
         end else begin
            res.reply_block = blocks_done_in + BLOCK_W'(1);
            if (past_end) begin
               res.reply_kind = KIND_FINAL;
               finished_in    = 1'b1;
            end else begin
               res.reply_kind    = KIND_DATA;
               res.flash_address = ADDR_W'(send_base);
               blocks_done_in    = blocks_done_in + BLOCK_W'(1);
            end
         end
      end

      if (err) begin
         res.reply_kind    = KIND_ERROR;
         res.reply_block   = '0;
         res.flash_address = '0;
         res.write_enable  = 1'b0;
         res.pad_start     = '0;
         res.last_block    = 1'b0;
         res.retry_fetch   = cfg.verify_only;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upload_mode_ff <= 1'b0;
         blocks_done_ff <= '0;
         finished_ff    <= 1'b0;
         wr_ptr_ff      <= 1'b0;
         rd_ptr_ff      <= 1'b0;
         count_ff       <= 2'd0;
      end else begin
         if (cmd_pop) begin
            upload_mode_ff <= upload_mode_in;
            blocks_done_ff <= blocks_done_in;
            finished_ff    <= finished_in;
         end
         wr_ptr_ff <= wr_ptr_ff ^ cmd_pop;
         rd_ptr_ff <= rd_ptr_ff ^ (rsp_pop && !rsp_empty);
         count_ff  <= count_ff + 2'(cmd_pop) - 2'(rsp_pop && !rsp_empty);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         res_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

// ===== test/tb_tftp_flash_transfer_control.sv =====
// ----------------------------------------------------------------------------
// tb_tftp_flash_transfer_control
// Self-checking bench for the TFTP flash transfer sequencer. A directed table
// covers bad opcodes, download order, long and short blocks, upload end,
// disabled uploads and verify mode. Random download and upload sessions with
// noise run next, under several register settings. Each reply is compared
// field by field with the row's expected reply or a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module tb_tftp_flash_transfer_control
   import tftc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // opcodes that the block answers with an error
   localparam logic [FUNC_W-1:0] OP_ZERO  = 16'd0;
   localparam logic [FUNC_W-1:0] OP_ERROR = 16'd5;
   localparam logic [FUNC_W-1:0] OP_SPARE = 16'd7;
   localparam logic [FUNC_W-1:0] OP_TOP   = 16'hFFFF;

   localparam rsp_type ERR_KEEP  = '{KIND_ERROR, 16'd0, 25'd0, 1'b0, 10'd0, 1'b0,
                                     LOADER_KEEP, 1'b0};
   localparam rsp_type ERR_STOP  = '{KIND_ERROR, 16'd0, 25'd0, 1'b0, 10'd0, 1'b0,
                                     LOADER_STOP, 1'b0};
   localparam rsp_type ERR_RETRY = '{KIND_ERROR, 16'd0, 25'd0, 1'b0, 10'd0, 1'b0,
                                     LOADER_KEEP, 1'b1};

   typedef enum logic {ROW_PKT, ROW_REG} row_kind_type;

   typedef struct packed {
      req_type pkt;
      logic    typed;
      rsp_type want;
   } packet_entry_type;

   typedef struct packed {
      row_kind_type           what;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      req_type                pkt;
      logic                   typed;
      rsp_type                want;
   } script_row_type;

   localparam int DIR_ROWS = 28;
   localparam script_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      '{ROW_PKT, '0, '0, '{OP_ZERO, 16'd0, 10'd0}, 1'b1, ERR_KEEP},
      '{ROW_PKT, '0, '0, '{OP_ERROR, 16'd0, 10'd0}, 1'b1, ERR_KEEP},
      '{ROW_PKT, '0, '0, '{OP_TOP, 16'hFFFF, 10'd1023}, 1'b1, ERR_KEEP},
      '{ROW_PKT, '0, '0, '{OP_ACK, 16'd0, 10'd0}, 1'b1, ERR_KEEP},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd1, 10'd512}, 1'b1,
        '{KIND_ACK, 16'd1, 25'd0, 1'b1, 10'd512, 1'b0, LOADER_STOP, 1'b0}},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd1, 10'd512}, 1'b1,
        '{KIND_ACK, 16'd1, 25'd0, 1'b0, 10'd0, 1'b0, LOADER_STOP, 1'b0}},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd3, 10'd512}, 1'b1, ERR_STOP},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd0, 10'd1}, 1'b1, ERR_STOP},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd2, 10'd1023}, 1'b1,
        '{KIND_ACK, 16'd2, 25'd512, 1'b1, 10'd512, 1'b0, LOADER_STOP, 1'b0}},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd3, 10'd0}, 1'b1,
        '{KIND_ACK, 16'd3, 25'd1024, 1'b1, 10'd0, 1'b1, LOADER_START, 1'b0}},
      '{ROW_PKT, '0, '0, '{OP_WRQ, 16'hFFFF, 10'd1023}, 1'b1,
        '{KIND_ACK, 16'd0, 25'd0, 1'b0, 10'd0, 1'b0, LOADER_KEEP, 1'b0}},
      '{ROW_REG, CSR_FLASH_END, 25'd1024, '0, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_RRQ, 16'hFFFF, 10'd0}, 1'b1,
        '{KIND_DATA, 16'd1, 25'd0, 1'b0, 10'd0, 1'b0, LOADER_STOP, 1'b0}},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd1, 10'd10}, 1'b1, ERR_STOP},
      '{ROW_PKT, '0, '0, '{OP_ACK, 16'd1, 10'd0}, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_ACK, 16'd0, 10'd0}, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_ACK, 16'd4, 10'd0}, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_ACK, 16'd2, 10'd0}, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_ACK, 16'd3, 10'd0}, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_ACK, 16'd3, 10'd0}, 1'b0, '0},
      '{ROW_REG, CSR_UPLOAD_ENABLE, 25'd0, '0, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_RRQ, 16'd0, 10'd0}, 1'b1, ERR_KEEP},
      '{ROW_PKT, '0, '0, '{OP_ACK, 16'd3, 10'd0}, 1'b1, ERR_KEEP},
      '{ROW_REG, CSR_VERIFY_ONLY, 25'd1, '0, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_WRQ, 16'd0, 10'd0}, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd1, 10'd100}, 1'b0, '0},
      '{ROW_PKT, '0, '0, '{OP_SPARE, 16'd0, 10'd0}, 1'b1, ERR_RETRY},
      '{ROW_PKT, '0, '0, '{OP_DATA, 16'd2, 10'd0}, 1'b0, '0}
   };

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   logic                   req_full;
   req_type                req_data  = '0;
   logic                   rsp_empty;
   logic                   rsp_pop   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   tftp_flash_transfer_control dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // sequencer model: session state and register copies
   logic              sess_upload   = 1'b0;
   logic [15:0]       sess_blocks   = '0;
   logic              sess_done     = 1'b0;
   logic [ADDR_W-1:0] cfg_flash_end = FLASH_END_RESET;
   logic              cfg_upload_en = 1'b1;
   logic              cfg_verify    = 1'b0;

   packet_entry_type packet_q [$];
   rsp_type          reply_q [$];
   packet_entry_type in_flight;
   rsp_type          predicted;
   int               idle_pct   = 14;
   int               fail_count = 0;

   function automatic rsp_type decide_reply(input req_type pkt);
      rsp_type          r;
      logic [16:0]      next_blk;
      logic [31:0]      base;
      logic [PAY_W-1:0] sat;
      logic             send_block;
      logic             bad;
      r          = '0;
      send_block = 1'b0;
      bad        = 1'b0;
      next_blk   = {1'b0, sess_blocks} + 17'd1;
      if (pkt.func == OP_RRQ && cfg_upload_en) begin
         sess_upload = 1'b1;
         sess_blocks = '0;
         sess_done   = 1'b0;
         r.loader_command = LOADER_STOP;
         send_block = 1'b1;
      end else if (pkt.func == OP_ACK && cfg_upload_en) begin
         if (!sess_upload || pkt.block_number < sess_blocks ||
             {1'b0, pkt.block_number} > next_blk) begin
            bad = 1'b1;
         end else begin
            sess_blocks = pkt.block_number;
            send_block  = 1'b1;
         end
      end else if (pkt.func == OP_WRQ) begin
         sess_upload = 1'b0;
         sess_blocks = '0;
         sess_done   = 1'b0;
         r.reply_kind = KIND_ACK;
      end else if (pkt.func == OP_DATA) begin
         r.loader_command = LOADER_STOP;
         if (sess_upload || pkt.block_number < sess_blocks ||
             {1'b0, pkt.block_number} > next_blk) begin
            bad = 1'b1;
         end else if (pkt.block_number == sess_blocks) begin
            // duplicate block: ack again, touch nothing
            r.reply_kind  = KIND_ACK;
            r.reply_block = pkt.block_number;
         end else begin
            sat  = (pkt.payload_length > BLOCK_BYTES) ? PAY_W'(BLOCK_BYTES)
                                                      : pkt.payload_length;
            base = 32'(pkt.block_number - 16'd1) * BLOCK_BYTES;
            r.flash_address = base[ADDR_W-1:0];
            r.write_enable  = !cfg_verify;
            r.pad_start     = sat;
            if (sat < BLOCK_BYTES) begin
               sess_done        = 1'b1;
               r.last_block     = 1'b1;
               r.loader_command = LOADER_START;
            end
            sess_blocks   = pkt.block_number;
            r.reply_kind  = KIND_ACK;
            r.reply_block = pkt.block_number;
         end
      end else begin
         bad = 1'b1;
      end

      if (send_block) begin
         if (sess_done) begin
            r.loader_command = LOADER_RESTART;
            r.reply_kind     = KIND_NONE;
         end else begin
            base          = 32'(sess_blocks) * BLOCK_BYTES;
            r.reply_block = sess_blocks + 16'd1;
            if (base > 32'(cfg_flash_end)) begin
               r.reply_kind = KIND_FINAL;
               sess_done    = 1'b1;
            end else begin
               r.reply_kind    = KIND_DATA;
               r.flash_address = base[ADDR_W-1:0];
               sess_blocks     = sess_blocks + 16'd1;
            end
         end
      end

      // error keeps only the loader command, with retry_fetch set in verify mode
      if (bad) begin
         r = '{KIND_ERROR, 16'd0, 25'd0, 1'b0, 10'd0, 1'b0, r.loader_command, cfg_verify};
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_reply(input rsp_type want, input rsp_type got);
      check_field("reply_kind", want.reply_kind, got.reply_kind);
      check_field("reply_block", want.reply_block, got.reply_block);
      check_field("flash_address", want.flash_address, got.flash_address);
      check_field("write_enable", want.write_enable, got.write_enable);
      check_field("pad_start", want.pad_start, got.pad_start);
      check_field("last_block", want.last_block, got.last_block);
      check_field("loader_command", want.loader_command, got.loader_command);
      check_field("retry_fetch", want.retry_fetch, got.retry_fetch);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predicted = decide_reply(in_flight.pkt);
            reply_q.push_back(in_flight.typed ? in_flight.want : predicted);
         end
         if (rsp_pop && !rsp_empty) begin
            if (reply_q.size() == 0) begin
               $display("%0t: reply expected none actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               check_reply(reply_q.pop_front(), rsp_data);
            end
         end
         // hold a transfer the block has not taken yet
         if (!(req_push && req_full)) begin
            if (packet_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               in_flight = packet_q.pop_front();
               req_data <= in_flight.pkt;
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic queue_packet(input logic [FUNC_W-1:0] func,
                               input logic [BLOCK_W-1:0] blk,
                               input logic [PAY_W-1:0] plen);
      packet_q.push_back('{'{func, blk, plen}, 1'b0, '0});
   endtask

   function automatic logic [PAY_W-1:0] pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) return PAY_W'(BLOCK_BYTES);
      if (roll < 90) return PAY_W'($urandom_range(BLOCK_BYTES - 1));
      return PAY_W'($urandom_range(1023, BLOCK_BYTES + 1));
   endfunction

   task automatic queue_random_traffic(input int count);
      int           added;
      int           len;
      int           roll;
      logic [15:0]  cur;
      added = 0;
      while (added < count) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            // download session: mostly in-order blocks
            queue_packet(OP_WRQ, 16'($urandom), 10'($urandom));
            cur = '0;
            len = $urandom_range(1, 12);
            repeat (len) begin
               roll = $urandom_range(99);
               if (roll < 78) begin
                  cur++;
                  queue_packet(OP_DATA, cur, pick_length());
               end else if (roll < 86) begin
                  queue_packet(OP_DATA, cur, pick_length());
               end else if (roll < 93) begin
                  queue_packet(OP_DATA, cur + 16'($urandom_range(2, 3)), pick_length());
               end else begin
                  queue_packet(OP_ACK, cur, 10'($urandom));
               end
            end
            added += len + 1;
         end else if (roll < 80) begin
            // upload session: client mostly acks each block sent, with noise
            queue_packet(OP_RRQ, 16'($urandom), 10'($urandom));
            cur = 16'd1;
            len = $urandom_range(1, 14);
            repeat (len) begin
               roll = $urandom_range(99);
               if (roll < 80) begin
                  queue_packet(OP_ACK, cur, 10'($urandom));
                  cur++;
               end else if (roll < 88) begin
                  queue_packet(OP_ACK, cur - 16'd2, 10'($urandom));
               end else if (roll < 94) begin
                  queue_packet(OP_ACK, 16'($urandom), 10'($urandom));
               end else begin
                  queue_packet(OP_DATA, cur, pick_length());
               end
            end
            added += len + 1;
         end else begin
            if ($urandom_range(1))
               queue_packet(16'($urandom_range(6)), 16'($urandom), 10'($urandom));
            else
               queue_packet(16'($urandom), 16'($urandom), 10'($urandom));
            added++;
         end
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (packet_q.size() != 0 || req_push || reply_q.size() != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FLASH_END:     cfg_flash_end = val[ADDR_W-1:0];
         CSR_UPLOAD_ENABLE: cfg_upload_en = val[0];
         CSR_VERIFY_ONLY:   cfg_verify    = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [ADDR_W-1:0] fe, input logic ue,
                               input logic vo, input int idle);
      wait_idle();
      write_reg(CSR_FLASH_END, fe);
      // upper bits of the flag registers must be dropped
      write_reg(CSR_UPLOAD_ENABLE, (CSR_DATA_W'($urandom) << 1) | CSR_DATA_W'(ue));
      write_reg(CSR_VERIFY_ONLY, (CSR_DATA_W'($urandom) << 1) | CSR_DATA_W'(vo));
      @(negedge clock);
      idle_pct = idle;
   endtask

   task automatic run_phase(input logic [ADDR_W-1:0] fe, input logic ue,
                            input logic vo, input int idle, input int count);
      program_regs(fe, ue, vo, idle);
      queue_random_traffic(count / 2);
      // drain mid-phase so the sender sits out a full emptying
      wait_idle();
      @(negedge clock);
      queue_random_traffic(count - count / 2);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].what == ROW_REG) begin
            wait_idle();
            write_reg(DIRECTED_ROWS[i].reg_index, DIRECTED_ROWS[i].reg_value);
            @(negedge clock);
         end else begin
            packet_q.push_back('{DIRECTED_ROWS[i].pkt, DIRECTED_ROWS[i].typed,
                                 DIRECTED_ROWS[i].want});
         end
      end

      run_phase(FLASH_END_RESET, 1'b1, 1'b0, 14, 160);
      run_phase('0, 1'b1, 1'b0, 14, 160);
      run_phase(25'd2047, 1'b1, 1'b1, 14, 160);
      run_phase('1, 1'b0, 1'b1, 14, 150);
      run_phase(25'd5119, 1'b1, 1'b0, 0, 160);
      run_phase(ADDR_W'($urandom_range(8191)), 1'b1, 1'($urandom_range(1)), 14, 160);

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_tftp_flash_transfer_control OK");
      end else begin
         $display("tb_tftp_flash_transfer_control NOT OK");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_tftp_flash_transfer_control NOT OK");
      $finish;
   end

endmodule
